>>> src/egs_pkg.sv
// ============================================================================
// egs_pkg - shared types and constants of the extended GCD unit
// Field types, controller states and the command/status bundles that join
// the controller to the datapath.
// ============================================================================
package egs_pkg;

    // field widths fixed by the port definition
    localparam int OPER_W    = 63;
    localparam int TARGET_W  = 64;
    localparam int DIVISOR_W = 63;
    localparam int COEFF_W   = 64;

    // default datapath width
    localparam int WIDTH_DEF = 64;

    // leading-zero skip of the divider, bits per cycle
    localparam int SKIP_BITS = 8;

    typedef logic [OPER_W-1:0]           t_oper;
    typedef logic signed [TARGET_W-1:0]  t_target;
    typedef logic [DIVISOR_W-1:0]        t_divisor;
    typedef logic signed [COEFF_W-1:0]   t_coeff;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MOD,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic div_start;  // start quotient of r0 / r1
        logic mod_start;  // start remainder of |target| / gcd
        logic step;       // apply one Euclid update
        logic emit;       // copy the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic r0_zero;
        logic r1_zero;
        logic div_busy;
    } t_status;

endpackage

>>> src/egs_if.sv
// ============================================================================
// egs_if - request and response channels of the extended GCD unit
// Valid/ready channels; a transfer happens when valid and ready are high.
// ============================================================================
interface egs_req_if;
    import egs_pkg::*;

    logic    valid;
    logic    ready;
    t_oper   value_a;
    t_oper   value_b;
    t_target target;

    modport source (output valid, output value_a, output value_b, output target,
                    input ready);
    modport sink   (input valid, input value_a, input value_b, input target,
                    output ready);
endinterface

interface egs_rsp_if;
    import egs_pkg::*;

    logic     valid;
    logic     ready;
    t_divisor divisor;
    t_coeff   coeff_a;
    t_coeff   coeff_b;
    logic     solvable;

    modport source (output valid, output divisor, output coeff_a, output coeff_b,
                    output solvable, input ready);
    modport sink   (input valid, input divisor, input coeff_a, input coeff_b,
                    input solvable, output ready);
endinterface

>>> src/egs_div.sv
// ============================================================================
// egs_div - restoring divider with quotient-product accumulation
// One quotient bit per cycle, MSB first. While the quotient is formed, the
// products q*mul_s and q*mul_t (mod 2^WIDTH) are built by shift-and-add, so
// the Euclid coefficient update needs no multiplier. Leading zero bytes of
// the dividend are skipped a byte per cycle while the partial remainder is 0.
// ============================================================================
module egs_div #(
    parameter int WIDTH = egs_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic [WIDTH-1:0] i_mul_s,
    input  logic [WIDTH-1:0] i_mul_t,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_prod_s,
    output logic [WIDTH-1:0] o_prod_t
);
    import egs_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dq, n_dq;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH-1:0] r_ps, n_ps;
    logic [WIDTH-1:0] r_pt, n_pt;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;

    logic [WIDTH-1:0] sh;
    logic [WIDTH:0]   diff;
    logic             ge;
    logic             skip;

    // one trial subtraction
    assign sh   = {r_rem[WIDTH-2:0], r_dq[WIDTH-1]};
    assign diff = {1'b0, sh} - {1'b0, r_dvs};
    assign ge   = ~diff[WIDTH];
    assign skip = (r_rem == '0) && (r_dq[WIDTH-1 -: SKIP_BITS] == '0)
                  && (r_cnt >= CW'(SKIP_BITS));

    // next state of the divider
    always_comb begin
        n_rem = r_rem;
        n_dq  = r_dq;
        n_dvs = r_dvs;
        n_ps  = r_ps;
        n_pt  = r_pt;
        n_cnt = r_cnt;
        if (i_start) begin
            n_rem = '0;
            n_dq  = i_dividend;
            n_dvs = i_divisor;
            n_ps  = '0;
            n_pt  = '0;
            n_cnt = CW'(WIDTH);
        end else if (r_busy) begin
            if (skip) begin
                // quotient bits are all zero here, products just shift
                n_dq  = r_dq << SKIP_BITS;
                n_ps  = r_ps << SKIP_BITS;
                n_pt  = r_pt << SKIP_BITS;
                n_cnt = r_cnt - CW'(SKIP_BITS);
            end else begin
                n_rem = ge ? diff[WIDTH-1:0] : sh;
                n_dq  = r_dq << 1;
                n_ps  = (r_ps << 1) + (ge ? i_mul_s : '0);
                n_pt  = (r_pt << 1) + (ge ? i_mul_t : '0);
                n_cnt = r_cnt - CW'(1);
            end
        end
        n_busy = (n_cnt != '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_dvs <= n_dvs;
        r_ps  <= n_ps;
        r_pt  <= n_pt;
    end

    assign o_busy   = r_busy;
    assign o_rem    = r_rem;
    assign o_prod_s = r_ps;
    assign o_prod_t = r_pt;

endmodule

>>> src/egs_dp.sv
// ============================================================================
// egs_dp - datapath of the extended GCD unit
// Remainder pair, both coefficient pairs, target magnitude and the result
// register. All arithmetic is carried out modulo 2^WIDTH.
// ============================================================================
module egs_dp #(
    parameter int WIDTH = egs_pkg::WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  egs_pkg::t_cmd       i_cmd,
    output egs_pkg::t_status    o_status,
    input  egs_pkg::t_oper      i_value_a,
    input  egs_pkg::t_oper      i_value_b,
    input  egs_pkg::t_target    i_target,
    output egs_pkg::t_divisor   o_divisor,
    output egs_pkg::t_coeff     o_coeff_a,
    output egs_pkg::t_coeff     o_coeff_b,
    output logic                o_solvable
);
    import egs_pkg::*;

    logic [WIDTH-2:0] r_r0, r_r1;
    logic [WIDTH-1:0] r_s0, r_s1, r_t0, r_t1;
    logic [WIDTH-1:0] r_mag;
    t_divisor         r_divisor;
    t_coeff           r_coeff_a, r_coeff_b;
    logic             r_solvable;

    logic [WIDTH-1:0] tgt;
    logic [WIDTH-1:0] mag;
    logic [WIDTH-1:0] div_dividend, div_divisor;
    logic             div_busy;
    logic [WIDTH-1:0] div_rem, prod_s, prod_t;

    // magnitude of the target taken from its low WIDTH bits
    assign tgt = i_target[WIDTH-1:0];
    assign mag = tgt[WIDTH-1] ? (WIDTH'(0) - tgt) : tgt;

    // divider operands: Euclid quotient or the final divisibility test
    assign div_dividend = i_cmd.mod_start ? r_mag : {1'b0, r_r0};
    assign div_divisor  = i_cmd.mod_start ? {1'b0, r_r0} : {1'b0, r_r1};

    egs_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start | i_cmd.mod_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mul_s    (r_s1),
        .i_mul_t    (r_t1),
        .o_busy     (div_busy),
        .o_rem      (div_rem),
        .o_prod_s   (prod_s),
        .o_prod_t   (prod_t)
    );

    // Euclid state: load on request, shift one step per update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0  <= i_value_a[WIDTH-2:0];
            r_r1  <= i_value_b[WIDTH-2:0];
            r_s0  <= WIDTH'(1);
            r_s1  <= '0;
            r_t0  <= '0;
            r_t1  <= WIDTH'(1);
            r_mag <= mag;
        end else if (i_cmd.step) begin
            r_r0 <= r_r1;
            r_r1 <= div_rem[WIDTH-2:0];
            r_s0 <= r_s1;
            r_s1 <= r_s0 - prod_s;
            r_t0 <= r_t1;
            r_t1 <= r_t0 - prod_t;
        end
    end

    // result register; gcd of zero divides only a zero target
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_divisor  <= t_divisor'(r_r0);
            r_coeff_a  <= t_coeff'(r_s0);
            r_coeff_b  <= t_coeff'(r_t0);
            r_solvable <= (r_r0 == '0) ? (r_mag == '0) : (div_rem == '0);
        end
    end

    assign o_status.r0_zero  = (r_r0 == '0);
    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.div_busy = div_busy;

    assign o_divisor  = r_divisor;
    assign o_coeff_a  = r_coeff_a;
    assign o_coeff_b  = r_coeff_b;
    assign o_solvable = r_solvable;

endmodule

>>> src/egs_ctrl.sv
// ============================================================================
// egs_ctrl - controller of the extended GCD unit
// Sequences request capture, Euclid steps, the final divisibility test and
// the hand-off to the response register.
// ============================================================================
module egs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  egs_pkg::t_status  i_status,
    output egs_pkg::t_cmd     o_cmd
);
    import egs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.r1_zero)      n_state = S_DIV;
                else if (!i_status.r0_zero) n_state = S_MOD;
                else                        n_state = S_DONE;
            end
            S_DIV: begin
                if (!i_status.div_busy) n_state = S_CHECK;
            end
            S_MOD: begin
                if (!i_status.div_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.div_start = !i_status.r1_zero;
                o_cmd.mod_start = i_status.r1_zero && !i_status.r0_zero;
            end
            S_DIV: begin
                o_cmd.step = !i_status.div_busy;
            end
            S_MOD: begin
            end
            S_DONE: begin
                o_cmd.emit = out_free;
            end
            default: begin
            end
        endcase
    end

    // response valid: set on emit, dropped when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit)       n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/extended_gcd_solvability.sv
// ============================================================================
// extended_gcd_solvability - extended Euclid with divisibility flag
// Returns gcd(a, b), Bezout coefficients and whether the gcd divides the
// target. One request in flight; the response sits in its own register.
// ============================================================================
//
//  channel  dir  payload                                   handshake
//  -------  ---  ----------------------------------------  -----------
//  i_req    in   value_a, value_b, target                  valid/ready
//  o_rsp    out  divisor, coeff_a, coeff_b, solvable       valid/ready
//
// Each Euclid step is a check and then a division of WIDTH one-bit steps;
// a zero byte shifted in while the partial remainder is zero is taken as a
// single step (leading zero bytes of the dividend always are). The final
// divisibility test is one more division; the shared divider sets the pace.
// Reset clears the controller and divider control; no clearing pass.
// A new request is taken only while the unit is idle; a stalled response
// holds its register, and the next request may be worked on meanwhile.
//
module extended_gcd_solvability #(
    parameter int WIDTH = egs_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    egs_req_if.sink     i_req,
    egs_rsp_if.source   o_rsp
);
    import egs_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    egs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    egs_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .o_status   (s_status),
        .i_value_a  (i_req.value_a),
        .i_value_b  (i_req.value_b),
        .i_target   (i_req.target),
        .o_divisor  (o_rsp.divisor),
        .o_coeff_a  (o_rsp.coeff_a),
        .o_coeff_b  (o_rsp.coeff_b),
        .o_solvable (o_rsp.solvable)
    );

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s_cmd))
        else $error("controller issued more than one command");

    // a started division is running in the next cycle
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.div_start || s_cmd.mod_start) |=> s_status.div_busy)
        else $error("divider did not start");

    // no request is taken while the divider works
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_status.div_busy |-> !i_req.ready)
        else $error("request accepted during division");

    // an emitted result shows up as a valid response
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |=> o_rsp.valid)
        else $error("emitted result not presented");

endmodule

>>> sim/tb_extended_gcd_solvability.sv
// ============================================================================
// tb_extended_gcd_solvability - self-checking bench of the extended GCD unit
// Sends operand pairs and targets through the request channel and checks gcd,
// Bezout coefficients and the divisibility flag of every response against an
// in-bench Euclid model or a typed answer. A short directed table runs first
// (zero operands, extreme values, most negative target, Fibonacci worst case),
// then random requests with random gaps and response stalls on both channels.
// ============================================================================
module tb_extended_gcd_solvability;
    timeunit 1ns;
    timeprecision 1ps;

    import egs_pkg::*;

    localparam int      RANDOM_ITEMS = 267;
    localparam int      STALL_LIMIT  = 40000;  // cycles with no transfer at all
    localparam int      DRAIN_CYCLES = 6500;   // about one worst-case request
    localparam t_oper   OPER_MAX     = {OPER_W{1'b1}};
    localparam t_oper   OPER_TOP     = t_oper'(1) << (OPER_W - 1);
    localparam t_target TARGET_MIN   = {1'b1, {(TARGET_W-1){1'b0}}};
    localparam t_target TARGET_MAX   = {1'b0, {(TARGET_W-1){1'b1}}};

    // one expected response
    typedef struct packed {
        t_divisor divisor;
        t_coeff   coeff_a;
        t_coeff   coeff_b;
        logic     solvable;
    } t_bezout;

    // one row of the directed table
    typedef struct {
        t_oper   a;
        t_oper   b;
        t_target c;
        logic    typed;   // answer below is used instead of the model
        t_bezout answer;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    egs_req_if req_if ();
    egs_rsp_if rsp_if ();

    extended_gcd_solvability u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_bezout bezout_pending[$];
    t_row    directed_rows[$];
    t_oper   fib_seq[0:92];
    int      mismatch_count = 0;
    bit      quiet = 1'b0;         // both sides run without idling
    logic    stage_typed;          // travels with the request payload
    t_bezout stage_answer;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Euclid iteration, coefficients kept modulo 2^64
    // ------------------------------------------------------------------------
    function automatic t_bezout bezout_predict(t_oper a, t_oper b, t_target c);
        logic [63:0] r0, r1, s0, s1, t0, t1, q, nr, ns, nt, mag;
        t_bezout     res;
        r0 = {1'b0, a};
        r1 = {1'b0, b};
        s0 = 64'd1;
        s1 = 64'd0;
        t0 = 64'd0;
        t1 = 64'd1;
        while (r1 != 64'd0) begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            ns = s0 - q * s1;
            nt = t0 - q * t1;
            r0 = r1;
            r1 = nr;
            s0 = s1;
            s1 = ns;
            t0 = t1;
            t1 = nt;
        end
        // magnitude of the target; the most negative value wraps to 2^63
        mag = c[TARGET_W-1] ? 64'd0 - 64'(c) : 64'(c);
        res.divisor  = r0[DIVISOR_W-1:0];
        res.coeff_a  = s0;
        res.coeff_b  = t0;
        res.solvable = (r0 == 64'd0) ? (mag == 64'd0) : ((mag % r0) == 64'd0);
        return res;
    endfunction

    function automatic t_bezout bezout_of(t_divisor g, t_coeff x, t_coeff y, logic ok);
        t_bezout res;
        res.divisor  = g;
        res.coeff_a  = x;
        res.coeff_b  = y;
        res.solvable = ok;
        return res;
    endfunction

    function automatic logic [63:0] rand_bits(int w);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        return v;
    endfunction

    task automatic add_row(t_oper a, t_oper b, t_target c, logic typed, t_bezout answer);
        t_row r;
        r.a      = a;
        r.b      = b;
        r.c      = c;
        r.typed  = typed;
        r.answer = answer;
        directed_rows.push_back(r);
    endtask

    // drive one request and hold it until the unit takes it
    task automatic send_request(t_oper a, t_oper b, t_target c, logic typed,
                                t_bezout answer);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.value_a <= a;
        req_if.value_b <= b;
        req_if.target  <= c;
        stage_typed    <= typed;
        stage_answer   <= answer;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready)) @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding response
    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (bezout_pending.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Response checker and expectation store
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_blk
        t_bezout want;
        if (i_rst_n === 1'b1) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (bezout_pending.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected response %0d %0d %0d %0b",
                             $time, rsp_if.divisor, rsp_if.coeff_a, rsp_if.coeff_b,
                             rsp_if.solvable);
                end else begin
                    want = bezout_pending.pop_front();
                    if (rsp_if.divisor !== want.divisor) begin
                        mismatch_count++;
                        $display("%0t: divisor expected %0d got %0d",
                                 $time, want.divisor, rsp_if.divisor);
                    end
                    if (rsp_if.coeff_a !== want.coeff_a) begin
                        mismatch_count++;
                        $display("%0t: coeff_a expected %0d got %0d",
                                 $time, want.coeff_a, rsp_if.coeff_a);
                    end
                    if (rsp_if.coeff_b !== want.coeff_b) begin
                        mismatch_count++;
                        $display("%0t: coeff_b expected %0d got %0d",
                                 $time, want.coeff_b, rsp_if.coeff_b);
                    end
                    if (rsp_if.solvable !== want.solvable) begin
                        mismatch_count++;
                        $display("%0t: solvable expected %0b got %0b",
                                 $time, want.solvable, rsp_if.solvable);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                bezout_pending.push_back(stage_typed ? stage_answer :
                    bezout_predict(req_if.value_a, req_if.value_b, req_if.target));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response side: random stalls of ready
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_if.valid && rsp_if.ready)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_oper       a, b, gf;
        t_target     c;
        logic [63:0] raw, cm;
        int          pick, w;

        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.value_a <= '0;
        req_if.value_b <= '0;
        req_if.target  <= '0;
        stage_typed    <= 1'b0;
        stage_answer   <= '0;

        fib_seq[0] = '0;
        fib_seq[1] = t_oper'(1);
        for (int k = 2; k <= 92; k++) fib_seq[k] = fib_seq[k-1] + fib_seq[k-2];

        // zero operands, extremes, most negative target
        add_row('0, '0, '0, 1'b1, bezout_of('0, 1, 0, 1'b1));
        add_row('0, '0, 1, 1'b1, bezout_of('0, 1, 0, 1'b0));
        add_row('0, '0, TARGET_MIN, 1'b1, bezout_of('0, 1, 0, 1'b0));
        add_row(5, '0, -10, 1'b1, bezout_of(5, 1, 0, 1'b1));
        add_row('0, 7, 3, 1'b1, bezout_of(7, 0, 1, 1'b0));
        add_row(OPER_MAX, '0, TARGET_MAX, 1'b1, bezout_of(OPER_MAX, 1, 0, 1'b1));
        add_row(OPER_MAX, '0, TARGET_MIN, 1'b1, bezout_of(OPER_MAX, 1, 0, 1'b0));
        add_row(OPER_TOP, '0, TARGET_MIN, 1'b1, bezout_of(OPER_TOP, 1, 0, 1'b1));
        add_row('0, OPER_MAX, -1, 1'b1, bezout_of(OPER_MAX, 0, 1, 1'b0));
        add_row(1, '0, -1, 1'b1, bezout_of(1, 1, 0, 1'b1));
        // general cases, checked by the model
        add_row(1, 1, TARGET_MIN, 1'b0, '0);
        add_row(OPER_MAX, OPER_MAX, '0, 1'b0, '0);
        add_row(OPER_MAX, OPER_MAX - 1, TARGET_MAX, 1'b0, '0);
        add_row(fib_seq[92], fib_seq[91], 1, 1'b0, '0);   // longest Euclid chain
        add_row(fib_seq[91], fib_seq[92], -1, 1'b0, '0);
        add_row(240, 46, 2, 1'b0, '0);
        add_row(46, 240, -4, 1'b0, '0);
        add_row(12, 18, 7, 1'b0, '0);
        add_row(6, 4, -6, 1'b0, '0);
        add_row(1, OPER_MAX, TARGET_MIN, 1'b0, '0);
        add_row(OPER_TOP, 3, 5, 1'b0, '0);
        add_row(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
        add_row(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                64'h5555_5555_5555_5555, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                         directed_rows[i].typed, directed_rows[i].answer);

        // sender holds off until the unit has answered everything
        drain_requests();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                if (n > 0 && $urandom_range(0, 2) == 0) drain_requests();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // one or both operands zero
                raw = rand_bits($urandom_range(1, 63));
                w   = $urandom_range(0, 2);
                a   = (w == 2) ? raw[62:0] : '0;
                b   = (w == 1) ? raw[62:0] : '0;
                raw = ($urandom_range(0, 1) == 0) ? 64'd0 : rand_bits($urandom_range(1, 64));
                c   = raw;
            end else if (pick < 12) begin
                // consecutive Fibonacci numbers: maximum step count for the size
                w = $urandom_range(2, 92);
                if ($urandom_range(0, 1) == 0) begin
                    a = fib_seq[w];
                    b = fib_seq[w-1];
                end else begin
                    a = fib_seq[w-1];
                    b = fib_seq[w];
                end
                raw = rand_bits(64);
                c   = raw;
            end else if (pick < 56) begin
                // shared factor, target mostly a multiple of it
                raw = rand_bits($urandom_range(1, 20));
                gf  = raw[62:0];
                if (gf == '0) gf = t_oper'(1);
                raw = rand_bits($urandom_range(0, 21));
                a   = gf * raw[62:0];
                raw = rand_bits($urandom_range(0, 21));
                b   = gf * raw[62:0];
                raw = rand_bits($urandom_range(0, 20));
                cm  = {1'b0, gf} * raw;
                if ($urandom_range(0, 3) == 0) cm = cm + 64'd1;
                if ($urandom_range(0, 1) == 0) cm = 64'd0 - cm;
                c   = cm;
            end else begin
                // wide operands, full-range target
                raw = rand_bits(($urandom_range(0, 1) == 0) ? 63 : $urandom_range(1, 62));
                a   = raw[62:0];
                raw = rand_bits(($urandom_range(0, 1) == 0) ? 63 : $urandom_range(1, 62));
                b   = raw[62:0];
                raw = rand_bits(($urandom_range(0, 1) == 0) ? 64 : $urandom_range(0, 63));
                if ($urandom_range(0, 3) == 0) raw = 64'd0 - raw;
                c   = raw;
            end
            send_request(a, b, c, 1'b0, '0);
        end

        drain_requests();
        // catch any stray response after the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && bezout_pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
